// ===== rtl/core/mfbp_pkg.sv =====
// Shared types, opcodes and sizing constants of the MSB-first bit packer.
package mfbp_pkg;

	// Zero-run length field is taken modulo 2^RUN_LENGTH_BITS (4 to 10).
	localparam int RUN_LENGTH_BITS = 10;
	// Width of the zero-run bit count, which includes the terminating one: run_length + 1.
	localparam int LEFT_W = RUN_LENGTH_BITS + 1;
	// Width for comparing the run count against the free bit count.
	localparam int CMP_W = (LEFT_W > 7) ? LEFT_W : 7;
	localparam logic [9:0] RUN_MASK = 10'((64'd1 << RUN_LENGTH_BITS) - 64'd1);

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Input opcodes.
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] value;
		logic [5:0]  field_bits;
		logic [9:0]  run_length;
	} item_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic [2:0]  byte_count;
		logic        last;
	} word_t;

	typedef enum logic [1:0] {
		KIND_PUT   = 2'd0,
		KIND_RUN   = 2'd1,
		KIND_FLUSH = 2'd2
	} kind_t;

	// Classified command: field width saturated, run count already + 1.
	typedef struct packed {
		kind_t             kind;
		logic [31:0]       value;
		logic [5:0]        nbits;
		logic [LEFT_W-1:0] left;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_rd_t;

endpackage

// ===== rtl/core/mfbp_front.sv =====
// Front end: accept input words, classify them and drop zero-width puts and unused opcodes.
module mfbp_front (
	input  logic            item_valid,
	output logic            item_stall,
	input  mfbp_pkg::item_t item,
	input  logic            q_full,
	output mfbp_pkg::q_wr_t wr
);

	logic                        keep;
	logic [5:0]                  nb_sat;
	logic [9:0]                  run_m;
	mfbp_pkg::kind_t             kind;

	always_comb begin
		nb_sat = (item.field_bits > 6'd32) ? 6'd32 : item.field_bits;
		run_m  = item.run_length & mfbp_pkg::RUN_MASK;
		case (item.opcode)
			mfbp_pkg::OP_PUT: begin
				kind = mfbp_pkg::KIND_PUT;
				keep = (nb_sat != 6'd0);
			end
			mfbp_pkg::OP_RUN: begin
				kind = mfbp_pkg::KIND_RUN;
				keep = 1'b1;
			end
			mfbp_pkg::OP_FLUSH: begin
				kind = mfbp_pkg::KIND_FLUSH;
				keep = 1'b1;
			end
			default: begin
				// unused opcode: drop
				kind = mfbp_pkg::KIND_PUT;
				keep = 1'b0;
			end
		endcase
	end

	assign item_stall   = q_full;
	assign wr.push      = item_valid && !q_full && keep;
	assign wr.cmd.kind  = kind;
	assign wr.cmd.value = item.value;
	assign wr.cmd.nbits = nb_sat;
	assign wr.cmd.left  = mfbp_pkg::LEFT_W'(run_m) + mfbp_pkg::LEFT_W'(1);

endmodule

// ===== rtl/core/mfbp_queue.sv =====
// Short command queue between the front and back ends.
module mfbp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  mfbp_pkg::q_wr_t wr,
	output logic            full,
	input  logic            pop,
	output mfbp_pkg::q_rd_t rd
);

	mfbp_pkg::cmd_t                mem_q [mfbp_pkg::QUEUE_DEPTH];
	logic [mfbp_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [mfbp_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [mfbp_pkg::QCNT_W-1:0]   count_q;

	function automatic logic [mfbp_pkg::QPTR_W-1:0] ptr_inc(
		input logic [mfbp_pkg::QPTR_W-1:0] p
	);
		if (p == mfbp_pkg::QPTR_W'(mfbp_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + mfbp_pkg::QPTR_W'(1);
	endfunction

	assign full     = (count_q == mfbp_pkg::QCNT_W'(mfbp_pkg::QUEUE_DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr.push && !pop) begin
				count_q <= count_q + mfbp_pkg::QCNT_W'(1);
			end else if (!wr.push && pop) begin
				count_q <= count_q - mfbp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/mfbp_back.sv =====
// Back end: pack commands into the accumulator and drive the output word register.
module mfbp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mfbp_pkg::q_rd_t rd,
	output logic            pop,
	output logic            word_valid,
	input  logic            word_stall,
	output mfbp_pkg::word_t word
);

	localparam int LW = mfbp_pkg::LEFT_W;
	localparam int CW = mfbp_pkg::CMP_W;

	logic [31:0]      acc_q, acc_d;
	logic [4:0]       used_q, used_d;
	logic             run_busy_q, run_busy_d;
	logic [LW-1:0]    left_q, left_d;
	logic             out_valid_q;
	mfbp_pkg::word_t  out_q;

	logic             adv;
	logic             emit;
	mfbp_pkg::word_t  emit_w;
	logic [5:0]       free;
	logic [LW-1:0]    left_cur;
	logic [CW-1:0]    left_x;
	logic [CW-1:0]    free_x;
	logic [CW-1:0]    rem;
	logic [4:0]       pos;
	logic [31:0]      run_w;
	logic [31:0]      mask;
	logic [31:0]      val_m;
	logic [6:0]       sh;
	logic [63:0]      wide;
	logic [5:0]       sum;

	always_comb begin
		adv      = rd.valid && (!out_valid_q || !word_stall);
		free     = 6'd32 - {1'b0, used_q};
		left_cur = run_busy_q ? left_q : rd.cmd.left;
		left_x   = CW'(left_cur);
		free_x   = CW'(free);
		rem      = left_x - free_x;
		pos      = 5'(free - 6'(left_cur));
		run_w    = acc_q | (32'd1 << pos);

		mask  = (rd.cmd.nbits >= 6'd32) ? 32'hFFFF_FFFF
		                                : ((32'd1 << rd.cmd.nbits) - 32'd1);
		val_m = rd.cmd.value & mask;
		sh    = 7'd64 - 7'(used_q) - 7'(rd.cmd.nbits);
		wide  = {acc_q, 32'd0} | ({32'd0, val_m} << sh);
		sum   = 6'(used_q) + rd.cmd.nbits;

		acc_d      = acc_q;
		used_d     = used_q;
		run_busy_d = run_busy_q;
		left_d     = left_q;
		emit       = 1'b0;
		emit_w     = '{out_word: acc_q, byte_count: 3'd4, last: 1'b1};
		pop        = 1'b0;

		if (adv) begin
			case (rd.cmd.kind)
				mfbp_pkg::KIND_PUT: begin
					pop = 1'b1;
					if (sum[5]) begin
						emit            = 1'b1;
						emit_w.out_word = wide[63:32];
						acc_d           = wide[31:0];
					end else begin
						acc_d = wide[63:32];
					end
					used_d = sum[4:0];
				end
				mfbp_pkg::KIND_RUN: begin
					if (left_x <= free_x) begin
						// final piece: zeros then the terminating one
						pop        = 1'b1;
						run_busy_d = 1'b0;
						if (left_x == free_x) begin
							emit            = 1'b1;
							emit_w.out_word = run_w;
							acc_d           = '0;
							used_d          = '0;
						end else begin
							acc_d  = run_w;
							used_d = used_q + 5'(left_cur);
						end
					end else begin
						// fill the word with zeros and emit it
						emit        = 1'b1;
						emit_w.last = (rem < CW'(32));
						acc_d       = '0;
						used_d      = '0;
						left_d      = LW'(rem);
						run_busy_d  = 1'b1;
					end
				end
				mfbp_pkg::KIND_FLUSH: begin
					pop = 1'b1;
					if (used_q != 5'd0) begin
						emit              = 1'b1;
						emit_w.byte_count = 3'((6'(used_q) + 6'd7) >> 3);
						acc_d             = '0;
						used_d            = '0;
					end
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			used_q      <= '0;
			run_busy_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_q      <= acc_d;
			used_q     <= used_d;
			run_busy_q <= run_busy_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!word_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		left_q <= left_d;
		if (emit) begin
			out_q <= emit_w;
		end
	end

	assign word_valid = out_valid_q;
	assign word       = out_q;

endmodule

// ===== rtl/core/msb_first_bit_packer.sv =====
// Top level of the MSB-first bit packer with zero-run (unary) code.
//
// Input channel (item_valid / item_stall / item): one word per command.
//   opcode put bits appends the low field_bits bits of value (0 adds nothing),
//   zero run appends run_length zeros and a one, flush pads to a byte
//   boundary and emits the occupied top bytes; opcode 3 is dropped.
// Output channel (word_valid / word_stall / word): packed 32-bit words, first
//   byte in bits 31 to 24, byte_count 4 except on flush, last set on the final
//   word caused by one input word.
// Structure: the front end classifies commands and drops zero-width puts and
//   unused opcodes, a two-entry queue decouples it from the back end, which
//   owns the accumulator and the output register.
// Throughput: while the output is not stalled, put bits and flush go through the
//   back end at one command per cycle; a zero run emits one word per cycle until
//   its final piece. The back-end accumulator loop sets this rate.
// Path: with the queue empty and the output free, the input word that completes a
//   word is written into the queue and then registered by the back end as output.
// Reset: arst_n clears the accumulator, the queue pointers and the output valid flag.
// Stall: while word_stall holds a valid word, the back end halts; the queue
//   keeps accepting until full, then item_stall rises.
module msb_first_bit_packer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  mfbp_pkg::item_t item,
	output logic            word_valid,
	input  logic            word_stall,
	output mfbp_pkg::word_t word
);

	mfbp_pkg::q_wr_t q_wr;
	mfbp_pkg::q_rd_t q_rd;
	logic            q_full;
	logic            q_pop;

	// Classify commands and drop zero-width puts and unused opcodes.
	mfbp_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.wr         (q_wr)
	);

	// Hold commands while the back end is busy.
	mfbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	// Pack bits and emit words.
	mfbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd         (q_rd),
		.pop        (q_pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

endmodule

// ===== rtl/core/mfbp_checker.sv =====
// Port checker of the bit packer and its bind to the top level.
module mfbp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            word_valid,
	input logic            word_stall,
	input mfbp_pkg::word_t word
);

	a_byte_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (word.byte_count == 3'd1 || word.byte_count == 3'd2 ||
		                word.byte_count == 3'd3 || word.byte_count == 3'd4))
		else $error("byte_count out of range");

	a_partial_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word.byte_count != 3'd4 |-> word.last)
		else $error("partial word without last");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (word.byte_count != 3'd1 || word.out_word[23:0] == 24'd0) &&
		               (word.byte_count != 3'd2 || word.out_word[15:0] == 16'd0) &&
		               (word.byte_count != 3'd3 || word.out_word[7:0] == 8'd0))
		else $error("flush padding not zero");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_stall |=> word_valid && $stable(word))
		else $error("stalled word changed");

endmodule

bind msb_first_bit_packer mfbp_checker u_mfbp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.word_valid (word_valid),
	.word_stall (word_stall),
	.word       (word)
);

// ===== tb/sv/msb_first_bit_packer_tb.sv =====
// Self-checking testbench for the MSB-first bit packer: directed table, random fields, stalls.
`timescale 1ns / 1ps

module msb_first_bit_packer_tb;

	// Opcode 3 has no meaning; the block must drop it without a word or a state change.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int MAX_WORDS_PER_ITEM = 32;
	localparam int RUN_FIELD_MASK = (1 << mfbp_pkg::RUN_LENGTH_BITS) - 1;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int HOLD_CYCLES = 240;
	// Leave a margin for a stray word after the last one due.
	localparam int DRAIN_CYCLES = 16;
	// Cycles in a row with no word moving on either channel before the run is declared hung.
	localparam int QUIET_LIMIT = 3000;

	localparam int SEND_IDLE[3] = '{21, 85, 0};
	localparam int RECV_IDLE[3] = '{85, 21, 0};

	// How a directed row gets its expectation: from the packing predictor, or typed in.
	typedef enum int {
		ROW_PREDICT,
		ROW_NO_WORD,
		ROW_ONE_WORD
	} row_kind_t;

	typedef struct {
		mfbp_pkg::item_t cmd;
		row_kind_t       form;
		mfbp_pkg::word_t typed;
	} dir_row_t;

	logic            clk;
	logic            arst_n = 1'b0;
	logic            item_valid = 1'b0;
	logic            item_stall;
	mfbp_pkg::item_t item = '0;
	logic            word_valid;
	logic            word_stall = 1'b0;
	mfbp_pkg::word_t word;

	// Packing predictor state: bits held from the top down, and the free bit count (1..32).
	logic [31:0]     acc_bits = '0;
	int              acc_free = 32;
	mfbp_pkg::word_t item_words[$];
	mfbp_pkg::word_t words_due[$];
	mfbp_pkg::word_t due_word;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          hold_ask = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	dir_row_t    dir_steps[$];

	msb_first_bit_packer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] low_ones(input int k);
		return (k >= 32) ? 32'hFFFF_FFFF : ((32'd1 << k) - 32'd1);
	endfunction

	// Append one packed word to this item's list; words past the per-item limit are dropped.
	function automatic void push_word(input logic [31:0] bits, input logic [2:0] nbytes);
		mfbp_pkg::word_t w;
		if (item_words.size() >= MAX_WORDS_PER_ITEM)
			return;
		w.out_word = bits;
		w.byte_count = nbytes;
		w.last = 1'b0;
		item_words.push_back(w);
	endfunction

	// Shift the low nb bits of val in below the bits already held, emitting on a full word.
	function automatic void shift_in(input logic [31:0] val, input int nb);
		int rest;
		rest = nb;
		if (rest == 0)
			return;
		if (rest >= acc_free) begin
			rest -= acc_free;
			acc_bits |= (val >> rest) & low_ones(acc_free);
			push_word(acc_bits, 3'd4);
			acc_bits = '0;
			acc_free = 32;
		end
		if (rest > 0) begin
			acc_free -= rest;
			acc_bits |= (val & low_ones(rest)) << acc_free;
		end
	endfunction

	// Work out the words one accepted item causes and advance the packing state.
	function automatic void pack_item(input mfbp_pkg::item_t it);
		int              left;
		int              used;
		mfbp_pkg::word_t tail;
		item_words.delete();
		case (it.opcode)
			mfbp_pkg::OP_PUT: begin
				// Widths above 32 saturate; width 0 adds nothing.
				shift_in(it.value, (it.field_bits > 6'd32) ? 32 : int'(it.field_bits));
			end
			mfbp_pkg::OP_RUN: begin
				// Unary code: run_length zeros then a one, fed in 31-bit pieces of zeros.
				left = (int'(it.run_length) & RUN_FIELD_MASK) + 1;
				while (left > 31) begin
					shift_in(32'd0, 31);
					left -= 31;
				end
				shift_in(32'd1, left);
			end
			mfbp_pkg::OP_FLUSH: begin
				// Empty accumulator: nothing to pad, no word.
				if (acc_free < 32) begin
					used = 32 - acc_free;
					push_word(acc_bits, 3'((used + 7) / 8));
					acc_bits = '0;
					acc_free = 32;
				end
			end
			default: begin
			end
		endcase
		if (item_words.size() > 0) begin
			tail = item_words.pop_back();
			tail.last = 1'b1;
			item_words.push_back(tail);
		end
	endfunction

	// Offer one word on the input channel, starting and ending on a falling edge.
	// The predictor always runs so its state tracks the block; typed rows override
	// what it says is due.
	task automatic send(input mfbp_pkg::item_t it, input row_kind_t form,
		input mfbp_pkg::word_t typed);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pack_item(it);
		case (form)
			ROW_PREDICT:  foreach (item_words[i]) words_due.push_back(item_words[i]);
			ROW_ONE_WORD: words_due.push_back(typed);
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	// Receiver: random stall at the configured rate, plus one long hold-off on request
	// so the queue fills and the block has to stall its input.
	always @(negedge clk) begin
		if (hold_ask && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			word_stall <= 1'b1;
			hold_left--;
		end else begin
			word_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check each word taken against the oldest one due, field by field.
	always @(posedge clk) begin
		if (word_valid && !word_stall) begin
			if (words_due.size() == 0) begin
				$error("word with nothing due: out_word %h byte_count %0d last %0b",
					word.out_word, word.byte_count, word.last);
				mismatch_count++;
			end else begin
				due_word = words_due.pop_front();
				if (word.out_word !== due_word.out_word) begin
					$error("out_word expected %h actual %h", due_word.out_word, word.out_word);
					mismatch_count++;
				end
				if (word.byte_count !== due_word.byte_count) begin
					$error("byte_count expected %0d actual %0d",
						due_word.byte_count, word.byte_count);
					mismatch_count++;
				end
				if (word.last !== due_word.last) begin
					$error("last expected %0b actual %0b", due_word.last, word.last);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (word_valid && !word_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int              ph;
		int              sent;
		int              pick;
		int              roll;
		mfbp_pkg::item_t nxt;

		// Directed rows: extremes of each field, every opcode, each corner of the packing.
		dir_steps = '{
			// Full-width put from empty comes straight out.
			'{'{mfbp_pkg::OP_PUT, 32'hDEADBEEF, 6'd32, 10'd0}, ROW_ONE_WORD,
				'{32'hDEADBEEF, 3'd4, 1'b1}},
			// Flush of an empty accumulator.
			'{'{mfbp_pkg::OP_FLUSH, 32'hFFFFFFFF, 6'd63, 10'd1023}, ROW_NO_WORD, '0},
			// Zero-width put adds nothing.
			'{'{mfbp_pkg::OP_PUT, 32'hFFFFFFFF, 6'd0, 10'd1023}, ROW_NO_WORD, '0},
			'{'{OP_UNUSED, 32'hFFFFFFFF, 6'd63, 10'd1023}, ROW_NO_WORD, '0},
			// Oversized width saturates to 32.
			'{'{mfbp_pkg::OP_PUT, 32'h12345678, 6'd63, 10'd0}, ROW_ONE_WORD,
				'{32'h12345678, 3'd4, 1'b1}},
			'{'{mfbp_pkg::OP_PUT, 32'hFFFFFFA5, 6'd8, 10'd0}, ROW_NO_WORD, '0},
			// Unused opcode on a partial word must leave it alone.
			'{'{OP_UNUSED, 32'h0, 6'd32, 10'd0}, ROW_NO_WORD, '0},
			'{'{mfbp_pkg::OP_FLUSH, 32'h0, 6'd0, 10'd0}, ROW_ONE_WORD,
				'{32'hA5000000, 3'd1, 1'b1}},
			// Shortest zero run is just the terminating one.
			'{'{mfbp_pkg::OP_RUN, 32'hFFFFFFFF, 6'd63, 10'd0}, ROW_NO_WORD, '0},
			'{'{mfbp_pkg::OP_FLUSH, 32'h0, 6'd0, 10'd0}, ROW_ONE_WORD,
				'{32'h80000000, 3'd1, 1'b1}},
			'{'{mfbp_pkg::OP_PUT, 32'h1, 6'd1, 10'd0}, ROW_NO_WORD, '0},
			// Full-width put across a word boundary.
			'{'{mfbp_pkg::OP_PUT, 32'h0, 6'd32, 10'd0}, ROW_PREDICT, '0},
			'{'{mfbp_pkg::OP_FLUSH, 32'h0, 6'd0, 10'd0}, ROW_ONE_WORD,
				'{32'h00000000, 3'd1, 1'b1}},
			'{'{mfbp_pkg::OP_PUT, 32'h7FFFFFFF, 6'd31, 10'd0}, ROW_NO_WORD, '0},
			'{'{mfbp_pkg::OP_RUN, 32'h0, 6'd0, 10'd30}, ROW_PREDICT, '0},
			'{'{mfbp_pkg::OP_FLUSH, 32'h0, 6'd0, 10'd0}, ROW_PREDICT, '0},
			// Longest run: 32 words out of one item.
			'{'{mfbp_pkg::OP_RUN, 32'h0, 6'd0, 10'd1023}, ROW_PREDICT, '0},
			// 31 zeros and a one fill exactly one word.
			'{'{mfbp_pkg::OP_RUN, 32'h0, 6'd0, 10'd31}, ROW_ONE_WORD,
				'{32'h00000001, 3'd4, 1'b1}},
			'{'{mfbp_pkg::OP_PUT, 32'h00ABCDEF, 6'd24, 10'd0}, ROW_NO_WORD, '0},
			'{'{mfbp_pkg::OP_FLUSH, 32'h0, 6'd0, 10'd0}, ROW_ONE_WORD,
				'{32'hABCDEF00, 3'd3, 1'b1}},
			'{'{mfbp_pkg::OP_PUT, 32'h0001FFFF, 6'd17, 10'd0}, ROW_NO_WORD, '0},
			'{'{mfbp_pkg::OP_RUN, 32'h0, 6'd0, 10'd62}, ROW_PREDICT, '0},
			'{'{mfbp_pkg::OP_FLUSH, 32'h0, 6'd0, 10'd0}, ROW_PREDICT, '0},
			'{'{mfbp_pkg::OP_PUT, 32'h0, 6'd32, 10'd0}, ROW_ONE_WORD,
				'{32'h00000000, 3'd4, 1'b1}}
		};

		// Hold reset, then release it on a falling edge.
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = SEND_IDLE[0];
		recv_idle_pct = RECV_IDLE[0];
		foreach (dir_steps[i])
			send(dir_steps[i].cmd, dir_steps[i].form, dir_steps[i].typed);

		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_idle_pct = RECV_IDLE[ph];
			// With no idling, ask for the long receiver hold-off while words keep coming.
			if (ph == 2)
				hold_ask = 1'b1;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				// Random filler in every field; the opcode picks which ones matter.
				nxt.value = $urandom();
				nxt.field_bits = 6'($urandom());
				nxt.run_length = 10'($urandom());
				pick = $urandom_range(99);
				if (pick < 45) begin
					nxt.opcode = mfbp_pkg::OP_PUT;
					if ($urandom_range(9) == 0)
						nxt.field_bits = 6'($urandom_range(63, 33));
					else
						nxt.field_bits = 6'($urandom_range(32));
				end else if (pick < 78) begin
					nxt.opcode = mfbp_pkg::OP_RUN;
					// Mostly short runs; a few long ones that spill over many words.
					roll = $urandom_range(99);
					if (roll < 88)
						nxt.run_length = 10'($urandom_range(40));
					else if (roll > 96)
						nxt.run_length = 10'd1023;
				end else if (pick < 94) begin
					nxt.opcode = mfbp_pkg::OP_FLUSH;
				end else begin
					nxt.opcode = OP_UNUSED;
				end
				send(nxt, ROW_PREDICT, '0);
				if (nxt.opcode != OP_UNUSED)
					sent++;
			end
			// Drop valid and pause until every word due has been taken.
			item_valid <= 1'b0;
			while (words_due.size() != 0)
				@(posedge clk);
			@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
